// ===== src/lsw_pkg.sv =====
// ----------------------------------------------------------------------------
// lsw_pkg
// shared types, codes and default sizes for the longest subsequence word select
// ----------------------------------------------------------------------------
package lsw_pkg;

   // default capacities
   localparam int TEXT_MAX_DEF = 64;
   localparam int WORD_MAX_DEF = 32;

   // item kinds
   localparam logic [1:0] KIND_TEXT   = 2'd0;
   localparam logic [1:0] KIND_WORD   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // running order of the word against the kept best word
   typedef enum logic [1:0] {
      ORD_EQ = 2'd0,
      ORD_LT = 2'd1,
      ORD_GT = 2'd2
   } order_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WCMP,
      ST_SCAN,
      ST_WEND,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   // input beat
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic       has_char;
      logic       is_end;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0] out_char;
      logic [5:0] best_length;
      logic       none_found;
      logic       text_clipped;
      logic       last_out;
   } rsp_type;

endpackage

// ===== src/lsw_text_mem.sv =====
// ----------------------------------------------------------------------------
// lsw_text_mem
// text byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module lsw_text_mem #(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/lsw_word_mem.sv =====
// ----------------------------------------------------------------------------
// lsw_word_mem
// two-bank word store: one bank holds the best word, the other the word in
// progress; a replacement swaps the bank roles instead of copying
// ----------------------------------------------------------------------------
module lsw_word_mem #(
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             we,
   input  logic             wbank,
   input  logic [IDX_W-1:0] widx,
   input  logic [7:0]       wdata,
   input  logic             rbank,
   input  logic [IDX_W-1:0] ridx,
   output logic [7:0]       rdata
);

   localparam int DEPTH = 2 ** (IDX_W + 1);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[{wbank, widx}] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[{rbank, ridx}];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/longest_subsequence_word_select.sv =====
// ----------------------------------------------------------------------------
// longest_subsequence_word_select
// text byte: written in idle. word byte: best-word read and compare, then a text
// scan one byte at a time through the one-read text port, then a keep step on a
// word's last byte; no new beat is taken until idle. finish: word memory read,
// output load, then drain before the next read; an empty result has no load.
// reset: synchronous; clears counts, flags and the sequencer, memories keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module longest_subsequence_word_select #(
   parameter int TEXT_MAX = lsw_pkg::TEXT_MAX_DEF,
   parameter int WORD_MAX = lsw_pkg::WORD_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lsw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lsw_pkg::rsp_type rsp_data
);

   localparam int TA_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
   localparam int TC_W = $clog2(TEXT_MAX + 1);
   localparam int WI_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
   localparam int WC_W = $clog2(WORD_MAX + 1);

   lsw_pkg::state_type state_ff, state_in;
   lsw_pkg::order_type order_ff, order_in;
   logic [7:0]         ch_ff, ch_in;
   logic               end_ff, end_in;
   logic [TC_W-1:0]    text_count_ff, text_count_in;
   logic               overflow_ff, overflow_in;
   logic [WC_W-1:0]    best_count_ff, best_count_in;
   logic               bank_ff, bank_in;
   logic [WC_W-1:0]    word_count_ff, word_count_in;
   logic [TC_W-1:0]    scan_ff, scan_in;
   logic [TC_W-1:0]    chk_ff, chk_in;
   logic               failed_ff, failed_in;
   logic [WC_W-1:0]    emit_k_ff, emit_k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lsw_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               text_we;
   logic [TA_W-1:0]    text_raddr;
   logic [7:0]         text_rdata;
   logic               word_we;
   logic [WI_W-1:0]    word_ridx;
   logic [7:0]         word_rdata;
   logic               accept;
   logic [TC_W-1:0]    chk_next;

   assign accept   = req_valid && !req_stall;
   assign chk_next = chk_ff + TC_W'(1);

   // stores
   lsw_text_mem #(
      .ADDR_W (TA_W)
   ) u_text_mem (
      .clock (clock),
      .we    (text_we),
      .waddr (text_count_ff[TA_W-1:0]),
      .wdata (req_data.ch),
      .raddr (text_raddr),
      .rdata (text_rdata)
   );

   lsw_word_mem #(
      .IDX_W (WI_W)
   ) u_word_mem (
      .clock (clock),
      .we    (word_we),
      .wbank (~bank_ff),
      .widx  (word_count_ff[WI_W-1:0]),
      .wdata (ch_ff),
      .rbank (bank_ff),
      .ridx  (word_ridx),
      .rdata (word_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lsw_pkg::ST_IDLE;
         order_ff      <= lsw_pkg::ORD_EQ;
         text_count_ff <= '0;
         overflow_ff   <= 1'b0;
         best_count_ff <= '0;
         bank_ff       <= 1'b0;
         word_count_ff <= '0;
         scan_ff       <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         order_ff      <= order_in;
         text_count_ff <= text_count_in;
         overflow_ff   <= overflow_in;
         best_count_ff <= best_count_in;
         bank_ff       <= bank_in;
         word_count_ff <= word_count_in;
         scan_ff       <= scan_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      end_ff      <= end_in;
      chk_ff      <= chk_in;
      emit_k_ff   <= emit_k_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      ch_in         = ch_ff;
      end_in        = end_ff;
      text_count_in = text_count_ff;
      overflow_in   = overflow_ff;
      best_count_in = best_count_ff;
      bank_in       = bank_ff;
      word_count_in = word_count_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      failed_in     = failed_ff;
      emit_k_in     = emit_k_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      text_we       = 1'b0;
      word_we       = 1'b0;
      text_raddr    = scan_ff[TA_W-1:0];
      word_ridx     = word_count_ff[WI_W-1:0];
      req_stall     = reset || (state_ff != lsw_pkg::ST_IDLE);

      case (state_ff)
         lsw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  lsw_pkg::KIND_TEXT: begin
                     if (req_data.has_char) begin
                        if (text_count_ff < TC_W'(TEXT_MAX)) begin
                           text_we       = 1'b1;
                           text_count_in = text_count_ff + TC_W'(1);
                        end else begin
                           overflow_in = 1'b1;
                        end
                     end
                  end
                  lsw_pkg::KIND_WORD: begin
                     ch_in  = req_data.ch;
                     end_in = req_data.is_end;
                     if (req_data.has_char && !failed_ff &&
                         word_count_ff < WC_W'(WORD_MAX)) begin
                        // best byte at this position is read now
                        state_in = lsw_pkg::ST_WCMP;
                     end else begin
                        if (req_data.has_char && !failed_ff) begin
                           failed_in = 1'b1;
                        end
                        if (req_data.is_end) begin
                           state_in = lsw_pkg::ST_WEND;
                        end
                     end
                  end
                  lsw_pkg::KIND_FINISH: begin
                     emit_k_in = '0;
                     state_in  = lsw_pkg::ST_EMIT_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         lsw_pkg::ST_WCMP: begin
            // running lexicographic compare against the best word
            if (order_ff == lsw_pkg::ORD_EQ && word_count_ff < best_count_ff) begin
               if (ch_ff < word_rdata) begin
                  order_in = lsw_pkg::ORD_LT;
               end else if (ch_ff > word_rdata) begin
                  order_in = lsw_pkg::ORD_GT;
               end
            end
            word_we       = 1'b1;
            word_count_in = word_count_ff + WC_W'(1);
            if (scan_ff >= text_count_ff) begin
               failed_in = 1'b1;
               scan_in   = text_count_ff;
               state_in  = end_ff ? lsw_pkg::ST_WEND : lsw_pkg::ST_IDLE;
            end else begin
               chk_in   = scan_ff;
               state_in = lsw_pkg::ST_SCAN;
            end
         end

         lsw_pkg::ST_SCAN: begin
            // one text byte checked per cycle, next one read ahead
            text_raddr = chk_next[TA_W-1:0];
            if (text_rdata == ch_ff) begin
               scan_in  = chk_next;
               state_in = end_ff ? lsw_pkg::ST_WEND : lsw_pkg::ST_IDLE;
            end else if (chk_next >= text_count_ff) begin
               failed_in = 1'b1;
               scan_in   = text_count_ff;
               state_in  = end_ff ? lsw_pkg::ST_WEND : lsw_pkg::ST_IDLE;
            end else begin
               chk_in = chk_next;
            end
         end

         lsw_pkg::ST_WEND: begin
            // keep the word if longer, or same length and smaller
            if (!failed_ff && word_count_ff != '0 &&
                (word_count_ff > best_count_ff ||
                 (word_count_ff == best_count_ff && order_ff == lsw_pkg::ORD_LT))) begin
               bank_in       = ~bank_ff;
               best_count_in = word_count_ff;
            end
            word_count_in = '0;
            scan_in       = '0;
            failed_in     = 1'b0;
            order_in      = lsw_pkg::ORD_EQ;
            state_in      = lsw_pkg::ST_IDLE;
         end

         lsw_pkg::ST_EMIT_RD: begin
            word_ridx = emit_k_ff[WI_W-1:0];
            if (!rsp_valid_ff) begin
               if (best_count_ff == '0) begin
                  // empty result marker
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.out_char     = 8'd0;
                  rsp_data_in.best_length  = 6'd0;
                  rsp_data_in.none_found   = 1'b1;
                  rsp_data_in.text_clipped = overflow_ff;
                  rsp_data_in.last_out     = 1'b1;
                  text_count_in            = '0;
                  overflow_in              = 1'b0;
                  word_count_in            = '0;
                  scan_in                  = '0;
                  failed_in                = 1'b0;
                  order_in                 = lsw_pkg::ORD_EQ;
                  state_in                 = lsw_pkg::ST_IDLE;
               end else begin
                  state_in = lsw_pkg::ST_EMIT_LD;
               end
            end
         end

         lsw_pkg::ST_EMIT_LD: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_char     = word_rdata;
            rsp_data_in.best_length  = 6'(best_count_ff);
            rsp_data_in.none_found   = 1'b0;
            rsp_data_in.text_clipped = overflow_ff;
            rsp_data_in.last_out     = (emit_k_ff + WC_W'(1)) == best_count_ff;
            if ((emit_k_ff + WC_W'(1)) == best_count_ff) begin
               // last beat loaded: clear text, best word and word in progress
               text_count_in = '0;
               overflow_in   = 1'b0;
               best_count_in = '0;
               word_count_in = '0;
               scan_in       = '0;
               failed_in     = 1'b0;
               order_in      = lsw_pkg::ORD_EQ;
               state_in      = lsw_pkg::ST_IDLE;
            end else begin
               emit_k_in = emit_k_ff + WC_W'(1);
               state_in  = lsw_pkg::ST_EMIT_RD;
            end
         end

         default: begin
            state_in = lsw_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/lsw_checker.sv =====
// ----------------------------------------------------------------------------
// lsw_checker
// port-level checks on the input and result channels, bound to the top level
// ----------------------------------------------------------------------------
module lsw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lsw_pkg::rsp_type rsp_data
);

   // no input beat is taken while reset is held
   a_reset_no_take: assert property (@(posedge clock)
      reset |-> !(req_valid && !req_stall))
      else $error("input beat accepted in reset");

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled result payload does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // the empty marker is a single final beat of length zero
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.none_found |->
         rsp_data.last_out && rsp_data.best_length == 6'd0 &&
         rsp_data.out_char == 8'd0)
      else $error("malformed empty result");

   // no result beat straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind longest_subsequence_word_select lsw_checker u_lsw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/longest_subsequence_word_select_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_subsequence_word_select_test
// Drives text, dictionary word and finish beats into the block. A local model
// tracks the stored text, the greedy scan and the kept best word, and queues
// the expected result beats. The checker compares each accepted result beat
// field by field against that queue. The sender idles in random bursts and
// the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module longest_subsequence_word_select_test;

   localparam int TEXT_CAP     = lsw_pkg::TEXT_MAX_DEF;
   localparam int WORD_CAP     = lsw_pkg::WORD_MAX_DEF;
   localparam int RANDOM_ITEMS = 240;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 200;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   lsw_pkg::req_type req_data  = '0;
   logic             rsp_stall = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   lsw_pkg::rsp_type rsp_data;

   // scoreboard bookkeeping
   int items_sent   = 0;
   int error_count  = 0;
   int burst_left   = 0;

   // model of the block: stored text, kept best word, word in progress
   logic [7:0]         txt_mem [TEXT_CAP];
   int                 txt_len  = 0;
   bit                 txt_clip = 1'b0;
   logic [7:0]         best_mem [WORD_CAP];
   int                 best_len = 0;
   logic [7:0]         cand_mem [WORD_CAP];
   int                 cand_len  = 0;
   int                 scan_idx  = 0;
   bit                 cand_dead = 1'b0;
   lsw_pkg::order_type cand_order = lsw_pkg::ORD_EQ;
   lsw_pkg::rsp_type   best_word_q [$];

   // stimulus side copy of the stored text and the word being built
   logic [7:0] txt_copy [$];
   logic [7:0] word_buf [$];

   // receiver stall pattern
   logic [15:0] stall_pat  = '0;
   int          stall_span = 0;
   int          stall_bit  = 0;

   always #5 clock = ~clock;

   longest_subsequence_word_select DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------

   task automatic drop_candidate();
      cand_len   = 0;
      scan_idx   = 0;
      cand_dead  = 1'b0;
      cand_order = lsw_pkg::ORD_EQ;
   endtask

   // advance the model by one accepted beat, queueing any result beats
   task automatic track_best_word(input lsw_pkg::req_type b);
      int               i;
      lsw_pkg::rsp_type r;
      case (b.kind)
         lsw_pkg::KIND_TEXT: begin
            if (b.has_char) begin
               if (txt_len < TEXT_CAP) begin
                  txt_mem[txt_len] = b.ch;
                  txt_len++;
               end else begin
                  txt_clip = 1'b1;
               end
            end
         end
         lsw_pkg::KIND_WORD: begin
            if (b.has_char && !cand_dead) begin
               if (cand_len >= WORD_CAP) begin
                  cand_dead = 1'b1;
               end else begin
                  // running order against the best word, decided at first difference
                  if (cand_order == lsw_pkg::ORD_EQ && cand_len < best_len) begin
                     if (b.ch < best_mem[cand_len])
                        cand_order = lsw_pkg::ORD_LT;
                     else if (b.ch > best_mem[cand_len])
                        cand_order = lsw_pkg::ORD_GT;
                  end
                  cand_mem[cand_len] = b.ch;
                  cand_len++;
                  // greedy scan forward through the text
                  i = scan_idx;
                  while (i < txt_len && txt_mem[i] != b.ch)
                     i++;
                  if (i < txt_len) begin
                     scan_idx = i + 1;
                  end else begin
                     scan_idx  = txt_len;
                     cand_dead = 1'b1;
                  end
               end
            end
            if (b.is_end) begin
               if (!cand_dead && cand_len > 0 && (cand_len > best_len ||
                   (cand_len == best_len && cand_order == lsw_pkg::ORD_LT))) begin
                  for (i = 0; i < cand_len; i++)
                     best_mem[i] = cand_mem[i];
                  best_len = cand_len;
               end
               drop_candidate();
            end
         end
         lsw_pkg::KIND_FINISH: begin
            if (best_len == 0) begin
               r.out_char     = 8'h00;
               r.best_length  = 6'd0;
               r.none_found   = 1'b1;
               r.text_clipped = txt_clip;
               r.last_out     = 1'b1;
               best_word_q.push_back(r);
            end else begin
               for (i = 0; i < best_len; i++) begin
                  r.out_char     = best_mem[i];
                  r.best_length  = best_len[5:0];
                  r.none_found   = 1'b0;
                  r.text_clipped = txt_clip;
                  r.last_out     = (i == best_len - 1);
                  best_word_q.push_back(r);
               end
            end
            txt_len  = 0;
            txt_clip = 1'b0;
            best_len = 0;
            drop_candidate();
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------

   // one input beat, in bursts with random gaps between them
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] ch,
                            input logic has, input logic tail);
      lsw_pkg::req_type b;
      int               gap;
      b.kind     = kind;
      b.ch       = ch;
      b.has_char = has;
      b.is_end   = tail;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
      track_best_word(b);
   endtask

   // beats that leave the block unchanged
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_beat(KIND_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         1: send_beat(lsw_pkg::KIND_TEXT, 8'($urandom_range(0, 255)), 1'b0,
                      1'($urandom_range(0, 1)));
         default: send_beat(lsw_pkg::KIND_WORD, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      endcase
   endtask

   task automatic add_text(input logic [7:0] c, input logic tail);
      send_beat(lsw_pkg::KIND_TEXT, c, 1'b1, tail);
      if (txt_copy.size() < TEXT_CAP)
         txt_copy.push_back(c);
   endtask

   // pick a subsequence of the stored text of the given length
   task automatic fill_subseq(input int want);
      int i;
      int skip;
      word_buf.delete();
      if (want > txt_copy.size())
         want = txt_copy.size();
      skip = txt_copy.size() - want;
      for (i = 0; i < txt_copy.size() && word_buf.size() < want; i++) begin
         if (skip > 0 && $urandom_range(0, 1))
            skip--;
         else
            word_buf.push_back(txt_copy[i]);
      end
   endtask

   // send word_buf, with text beats and noise sometimes slipped in between
   task automatic send_word(input logic [7:0] base, input int span);
      int k;
      bit blank_end;
      blank_end = (word_buf.size() == 0) || ($urandom_range(0, 4) == 0);
      for (k = 0; k < word_buf.size(); k++) begin
         if ($urandom_range(0, 11) == 0)
            add_text(8'(base + $urandom_range(0, span)), 1'b0);
         if ($urandom_range(0, 11) == 0)
            send_noise();
         send_beat(lsw_pkg::KIND_WORD, word_buf[k], 1'b1,
                   k == word_buf.size() - 1 && !blank_end);
      end
      if (blank_end)
         send_beat(lsw_pkg::KIND_WORD, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // one text, a handful of words and a finish
   task automatic run_round(input bit big);
      logic [7:0] base;
      int         span;
      int         n_text;
      int         n_words;
      int         i;
      int         style;
      int         len;
      base = 8'($urandom_range(0, 255));
      span = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 5);
      txt_copy.delete();
      if (big)
         n_text = $urandom_range(TEXT_CAP + 1, TEXT_CAP + 6);
      else
         n_text = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      // text load, an empty text just carries its end mark
      if (n_text == 0)
         send_beat(lsw_pkg::KIND_TEXT, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      for (i = 0; i < n_text; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_noise();
         add_text(8'(base + $urandom_range(0, span)), i == n_text - 1);
      end
      // full-length match, then one byte too long
      if (big) begin
         fill_subseq(WORD_CAP);
         send_word(base, span);
         fill_subseq(WORD_CAP + 1);
         send_word(base, span);
      end
      n_words = $urandom_range(1, 6);
      for (i = 0; i < n_words; i++) begin
         style = $urandom_range(0, 19);
         if (style < 11) begin
            fill_subseq($urandom_range(0, txt_copy.size() < 8 ? txt_copy.size() : 8));
         end else begin
            len = (style < 19) ? $urandom_range(0, 6) :
                                 $urandom_range(WORD_CAP + 1, WORD_CAP + 3);
            word_buf.delete();
            repeat (len) word_buf.push_back(8'(base + $urandom_range(0, span)));
         end
         send_word(base, span);
      end
      send_beat(lsw_pkg::KIND_FINISH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // finish with nothing loaded gives the empty marker
   task automatic test_empty_finish();
      send_beat(lsw_pkg::KIND_FINISH, 8'h00, 1'b0, 1'b0);
   endtask

   // byte extremes, ignored beats, end mark and the spare kind
   task automatic test_text_load();
      send_beat(lsw_pkg::KIND_TEXT, 8'hFF, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h00, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h80, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h41, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h55, 1'b0, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h42, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h43, 1'b1, 1'b1);
      send_beat(KIND_SPARE, 8'hAA, 1'b1, 1'b1);
   endtask

   // replacement rules over the text ff 00 80 41 42 43
   task automatic test_word_select();
      // first match becomes the best word
      send_beat(lsw_pkg::KIND_WORD, 8'hFF, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h41, 1'b1, 1'b1);
      // same length and smaller wins, blank beat in the middle
      send_beat(lsw_pkg::KIND_WORD, 8'h00, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h7E, 1'b0, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h42, 1'b1, 1'b1);
      // empty word
      send_beat(lsw_pkg::KIND_WORD, 8'h33, 1'b0, 1'b1);
      // not a subsequence
      send_beat(lsw_pkg::KIND_WORD, 8'h43, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h00, 1'b1, 1'b1);
      // same length but greater keeps the best word
      send_beat(lsw_pkg::KIND_WORD, 8'h80, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h42, 1'b1, 1'b1);
      // longer word, its last byte arrives as text mid-word
      send_beat(lsw_pkg::KIND_WORD, 8'h00, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h80, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_TEXT, 8'h44, 1'b1, 1'b0);
      send_beat(lsw_pkg::KIND_WORD, 8'h44, 1'b1, 1'b1);
   endtask

   // finish ignores its own fields and emits the kept word
   task automatic test_finish_emit();
      send_beat(lsw_pkg::KIND_FINISH, 8'hFF, 1'b1, 1'b1);
   endtask

   // random rounds, one of them overfilling the text with a full-length word
   task automatic test_random_rounds();
      int round;
      int start;
      round = 0;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         run_round(round == 1);
         round++;
      end
   endtask

   // ------------------------------------------------------------------------
   // receiver and checker
   // ------------------------------------------------------------------------

   // stall pattern, swapped for a new one when its random span runs out
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_span = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0: stall_pat = '0;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom | $urandom);
            default: stall_pat = 16'($urandom & $urandom);
         endcase
      end
      stall_span--;
      rsp_stall <= stall_pat[stall_bit];
      stall_bit = (stall_bit + 1) % 16;
   end

   // compare each accepted result beat with the oldest expected beat
   always @(posedge clock) begin
      lsw_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (best_word_q.size() == 0) begin
            $error("unexpected result beat %h", rsp_data);
            error_count++;
         end else begin
            want = best_word_q.pop_front();
            if (rsp_data.out_char !== want.out_char) begin
               $error("out_char: expected %h, actual %h", want.out_char, rsp_data.out_char);
               error_count++;
            end
            if (rsp_data.best_length !== want.best_length) begin
               $error("best_length: expected %0d, actual %0d",
                      want.best_length, rsp_data.best_length);
               error_count++;
            end
            if (rsp_data.none_found !== want.none_found) begin
               $error("none_found: expected %b, actual %b",
                      want.none_found, rsp_data.none_found);
               error_count++;
            end
            if (rsp_data.text_clipped !== want.text_clipped) begin
               $error("text_clipped: expected %b, actual %b",
                      want.text_clipped, rsp_data.text_clipped);
               error_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out: expected %b, actual %b", want.last_out, rsp_data.last_out);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      int drain_cycles;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_finish();
      test_text_load();
      test_word_select();
      test_finish_emit();
      test_random_rounds();

      @(negedge clock);
      req_valid <= 1'b0;

      // let outstanding result beats drain, then allow for any late beat
      drain_cycles = 0;
      while (best_word_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (best_word_q.size() != 0) begin
         $error("%0d expected result beats never arrived", best_word_q.size());
         error_count++;
      end

      if (error_count == 0)
         $display("longest_subsequence_word_select_test passed");
      else
         $display("longest_subsequence_word_select_test failed");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("longest_subsequence_word_select_test failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/lsw_pkg.sv
src/lsw_text_mem.sv
src/lsw_word_mem.sv
src/longest_subsequence_word_select.sv
src/lsw_checker.sv
verif/longest_subsequence_word_select_test.sv
